// ===== hdl/itoa_pkg.sv =====
`timescale 1ns / 1ps

package itoa_pkg;

   // Default value width of the number field
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // Radix limits and the one radix that writes a sign
   localparam logic [5:0] MIN_RADIX  = 6'd2;
   localparam logic [5:0] MAX_RADIX  = 6'd36;
   localparam logic [5:0] SIGN_RADIX = 6'd10;

   // Special characters
   localparam logic [7:0] MINUS_CHAR = 8'h2d;
   localparam logic [7:0] EMPTY_CHAR = 8'h00;
   localparam logic [7:0] ZERO_CHAR  = 8'h30;
   localparam logic [7:0] ALPHA_CHAR = 8'h61;
   localparam logic [5:0] TEN        = 6'd10;

   // Divider control and status
   typedef struct packed {
      logic       start;
      logic [5:0] divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic       done;
      logic [5:0] remainder;
   } div_status_type;

   // Digit stack control
   typedef struct packed {
      logic       push;
      logic       pop;
      logic [7:0] push_char;
   } stack_ctrl_type;

   // Map a digit value 0..35 to its lower-case ASCII character
   function automatic logic [7:0] digit_char(input logic [5:0] digit);
      logic [7:0] ch;
      if (digit < TEN) begin
         ch = ZERO_CHAR + {2'b00, digit};
      end else begin
         ch = ALPHA_CHAR + {2'b00, digit - TEN};
      end
      return ch;
   endfunction

endpackage

// ===== hdl/integer_to_radix_string.sv =====
`timescale 1ns / 1ps

// Integer to radix string.
// The req channel takes one item: a signed number and a radix. The rsp
// channel returns its lower-case ASCII digits, most significant first, one
// character per item, with tlast on the final one. In radix 10 a negative
// number is written as '-' and its magnitude; other radices read the bits
// as unsigned. A radix outside 2..36 returns one NUL character with tlast.
// Each digit is one pass of a shared restoring divider, and a minus sign,
// if any, is pushed after the last digit. Characters are delivered one per
// cycle while rsp_tready is high. Digits go onto a stack as they appear and
// are read back in reverse order.
// req_tready is high only while the block is idle; one item is in work at a
// time. When the receiver holds rsp_tready low, the current character and
// tlast hold until taken. Reset (synchronous, active high) drops any item in
// work and returns the block to idle with an empty stack.
module integer_to_radix_string #(
   parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [VALUE_WIDTH-1:0] number, [VALUE_WIDTH+5:VALUE_WIDTH] radix, rest zero
   input  logic [((VALUE_WIDTH+6+7)/8)*8-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] character
   output logic [7:0]                        rsp_tdata,
   output logic                              rsp_tlast
);

   typedef enum logic [2:0] {
      IDLE,
      START,
      DIVIDE,
      SIGN,
      EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [5:0]             radix_ff, radix_in;
   logic                   neg_ff, neg_in;

   logic [VALUE_WIDTH-1:0] req_number;
   logic [5:0]             req_radix;
   logic                   radix_ok;
   logic                   req_neg;

   itoa_pkg::div_ctrl_type   div_ctrl;
   itoa_pkg::div_status_type div_status;
   logic [VALUE_WIDTH-1:0]   quotient;
   itoa_pkg::stack_ctrl_type stack_ctrl;
   logic [7:0]               top_char;
   logic                     stack_empty;
   logic                     stack_last;

   // Unpack the request
   assign req_number = req_tdata[VALUE_WIDTH-1:0];
   assign req_radix  = req_tdata[VALUE_WIDTH+5:VALUE_WIDTH];
   assign radix_ok   = (req_radix >= itoa_pkg::MIN_RADIX) &&
                       (req_radix <= itoa_pkg::MAX_RADIX);
   assign req_neg    = (req_radix == itoa_pkg::SIGN_RADIX) &&
                       req_number[VALUE_WIDTH-1];

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = (state_ff == EMIT);
   assign rsp_tdata  = top_char;
   assign rsp_tlast  = stack_last;

   // Sequence the digit passes
   always_comb begin
      state_in             = state_ff;
      value_in             = value_ff;
      radix_in             = radix_ff;
      neg_in               = neg_ff;
      div_ctrl.start       = 1'b0;
      div_ctrl.divisor     = radix_ff;
      stack_ctrl.push      = 1'b0;
      stack_ctrl.pop       = 1'b0;
      stack_ctrl.push_char = itoa_pkg::digit_char(div_status.remainder);
      unique case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               radix_in = req_radix;
               neg_in   = req_neg;
               value_in = req_neg ? (~req_number + 1'b1) : req_number;
               if (radix_ok) begin
                  state_in = START;
               end else begin
                  stack_ctrl.push      = 1'b1;
                  stack_ctrl.push_char = itoa_pkg::EMPTY_CHAR;
                  state_in             = EMIT;
               end
            end
         end
         START: begin
            div_ctrl.start = 1'b1;
            state_in       = DIVIDE;
         end
         DIVIDE: begin
            if (div_status.done) begin
               stack_ctrl.push = 1'b1;
               value_in        = quotient;
               if (quotient != '0) begin
                  state_in = START;
               end else if (neg_ff) begin
                  state_in = SIGN;
               end else begin
                  state_in = EMIT;
               end
            end
         end
         SIGN: begin
            stack_ctrl.push      = 1'b1;
            stack_ctrl.push_char = itoa_pkg::MINUS_CHAR;
            state_in             = EMIT;
         end
         EMIT: begin
            if (rsp_tready) begin
               stack_ctrl.pop = 1'b1;
               if (stack_last) begin
                  state_in = IDLE;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
      // Never pop past the bottom
      if (stack_empty) begin
         stack_ctrl.pop = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
      value_ff <= value_in;
      radix_ff <= radix_in;
      neg_ff   <= neg_in;
   end

   itoa_divider #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (value_ff),
      .status   (div_status),
      .quotient (quotient)
   );

   itoa_digit_stack #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_stack (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (stack_ctrl),
      .top_char (top_char),
      .empty    (stack_empty),
      .last     (stack_last)
   );

endmodule

// ===== hdl/itoa_divider.sv =====
`timescale 1ns / 1ps

// Restoring divider: one quotient bit per cycle, remainder below the radix
module itoa_divider #(
   parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  itoa_pkg::div_ctrl_type     ctrl,
   input  logic [VALUE_WIDTH-1:0]     dividend,
   output itoa_pkg::div_status_type   status,
   output logic [VALUE_WIDTH-1:0]     quotient
);

   localparam int CntW = $clog2(VALUE_WIDTH);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CntW-1:0]        cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [5:0]             rem_ff, rem_in;
   logic [5:0]             div_ff, div_in;
   logic [6:0]             trial;
   logic [6:0]             diff;
   logic                   fits;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial = {rem_ff, quo_ff[VALUE_WIDTH-1]};
      diff  = trial - {1'b0, div_ff};
      fits  = trial >= {1'b0, div_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(VALUE_WIDTH - 1);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = ctrl.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_WIDTH-2:0], fits};
         rem_in = fits ? diff[5:0] : trial[5:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign status.done      = done_ff;
   assign status.remainder = rem_ff;
   assign quotient         = quo_ff;

endmodule

// ===== hdl/itoa_digit_stack.sv =====
`timescale 1ns / 1ps

// Last-in first-out character stack, built as a shift line; top at entry 0
module itoa_digit_stack #(
   parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  itoa_pkg::stack_ctrl_type ctrl,
   output logic [7:0]               top_char,
   output logic                     empty,
   output logic                     last
);

   localparam int Depth = VALUE_WIDTH + 1;
   localparam int CntW  = $clog2(Depth + 1);

   logic [7:0]      stk_ff [Depth];
   logic [7:0]      stk_in [Depth];
   logic [CntW-1:0] cnt_ff, cnt_in;

   // Shift up on push, down on pop
   always_comb begin
      for (int i = 0; i < Depth; i++) begin
         stk_in[i] = stk_ff[i];
      end
      cnt_in = cnt_ff;
      if (ctrl.push) begin
         stk_in[0] = ctrl.push_char;
         for (int i = 1; i < Depth; i++) begin
            stk_in[i] = stk_ff[i-1];
         end
         cnt_in = cnt_ff + 1'b1;
      end else if (ctrl.pop) begin
         for (int i = 0; i < Depth - 1; i++) begin
            stk_in[i] = stk_ff[i+1];
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      for (int i = 0; i < Depth; i++) begin
         stk_ff[i] <= stk_in[i];
      end
   end

   assign top_char = stk_ff[0];
   assign empty    = cnt_ff == '0;
   assign last     = cnt_ff == CntW'(1);

endmodule
